### rtl/slc_pkg.sv
`default_nettype none

package slc_pkg;

  // Field widths of one request and one result.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 4;

  // Reset value of the shard capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Request kinds.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Outcome of one lookup, passed from the way logic to the result register.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lookup_res_t;

endpackage

`default_nettype wire

### rtl/slc_ram.sv
`default_nettype none

module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   wen,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   ren,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read of the address being
  // written in the same cycle returns the old contents.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/slc_shard_sel.sv
`default_nettype none

module slc_shard_sel #(
  parameter int SHARD_COUNT = 8
) (
  input  wire logic [slc_pkg::KEY_W-1:0] key,
  output logic      [slc_pkg::KEY_W-1:0] quot,
  input  wire logic [slc_pkg::KEY_W-1:0] key_q,
  input  wire logic [slc_pkg::KEY_W-1:0] quot_q,
  output logic      [((SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1)-1:0] shard
);

  localparam int SHARD_W = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
  localparam int SHIFT   = slc_pkg::KEY_W + ((SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 0);
  localparam int PROD_W  = 2 * slc_pkg::KEY_W + 1;
  // Rounded-up reciprocal: exact quotient for every key value.
  localparam logic [PROD_W-1:0] RECIP =
    ((PROD_W'(1) << SHIFT) + PROD_W'(SHARD_COUNT) - PROD_W'(1)) / PROD_W'(SHARD_COUNT);

  logic [PROD_W-1:0]         prod;
  logic [slc_pkg::KEY_W-1:0] back;
  logic [slc_pkg::KEY_W-1:0] rem;

  // Quotient of the incoming key by the shard count, taken at the input.
  always_comb begin
    prod = PROD_W'(key) * RECIP;
    quot = slc_pkg::KEY_W'(prod >> SHIFT);
  end

  // Remainder from the registered key and quotient selects the shard.
  always_comb begin
    back  = quot_q * slc_pkg::KEY_W'(SHARD_COUNT);
    rem   = key_q - back;
    shard = rem[SHARD_W-1:0];
  end

endmodule

`default_nettype wire

### rtl/slc_way_logic.sv
`default_nettype none

module slc_way_logic #(
  parameter int WAYS = 8
) (
  input  wire logic                    cmd,
  input  wire logic [slc_pkg::KEY_W-1:0] key,
  input  wire logic [slc_pkg::VAL_W-1:0] value_in,
  input  wire logic [slc_pkg::CAP_W-1:0] cap,
  input  wire logic [WAYS-1:0]         valid_row,
  input  wire logic [WAYS*(slc_pkg::KEY_W + slc_pkg::VAL_W +
                    ((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] row,
  output logic      [WAYS-1:0]         new_valid,
  output logic      [WAYS*(slc_pkg::KEY_W + slc_pkg::VAL_W +
                    ((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] new_row,
  output slc_pkg::lookup_res_t         res
);

  localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W = slc_pkg::KEY_W + slc_pkg::VAL_W + AGE_W;
  localparam int COUNT_W = $clog2(WAYS + 1);
  localparam int CMP_W   = (COUNT_W > slc_pkg::CAP_W) ? COUNT_W : slc_pkg::CAP_W;
  localparam int VAL_LSB = AGE_W;
  localparam int KEY_LSB = AGE_W + slc_pkg::VAL_W;

  logic [slc_pkg::KEY_W-1:0] e_key [WAYS];
  logic [slc_pkg::VAL_W-1:0] e_val [WAYS];
  logic [AGE_W-1:0]          e_age [WAYS];
  logic [slc_pkg::KEY_W-1:0] n_key [WAYS];
  logic [slc_pkg::VAL_W-1:0] n_val [WAYS];
  logic [AGE_W-1:0]          n_age [WAYS];

  logic [COUNT_W-1:0]        count;
  logic [WAYS-1:0]           match_oh;
  logic [WAYS-1:0]           free_oh;
  logic [WAYS-1:0]           oldest_oh;
  logic [WAYS-1:0]           slot_oh;
  logic                      found;
  logic                      free_seen;
  logic                      evict;
  logic [CMP_W-1:0]          cap_min;
  logic [AGE_W-1:0]          hit_age;
  logic [slc_pkg::VAL_W-1:0] hit_value;

  // Split the shard row into its ways.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      e_key[w] = row[w*ENTRY_W + KEY_LSB +: slc_pkg::KEY_W];
      e_val[w] = row[w*ENTRY_W + VAL_LSB +: slc_pkg::VAL_W];
      e_age[w] = row[w*ENTRY_W +: AGE_W];
    end
  end

  // Occupancy of the shard.
  always_comb begin
    count = '0;
    for (int w = 0; w < WAYS; w++) begin
      count = count + COUNT_W'(valid_row[w]);
    end
  end

  // Compare all ways with the key and find the first free way.
  always_comb begin
    match_oh  = '0;
    free_oh   = '0;
    found     = 1'b0;
    free_seen = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_row[w] && (e_key[w] == key) && !found) begin
        match_oh[w] = 1'b1;
        found       = 1'b1;
      end
      if (!valid_row[w] && !free_seen) begin
        free_oh[w] = 1'b1;
        free_seen  = 1'b1;
      end
    end
  end

  // Valid ages are always 0 to count-1, so the least recent way holds count-1.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      oldest_oh[w] = valid_row[w] && (COUNT_W'(e_age[w]) == (count - COUNT_W'(1)));
    end
  end

  // Data and age of the way that hit.
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (match_oh[w]) begin
        hit_age   = e_age[w];
        hit_value = e_val[w];
      end
    end
  end

  // A capacity of zero counts as one; above the way count it saturates.
  always_comb begin
    cap_min = (cap == '0) ? CMP_W'(1) : CMP_W'(cap);
    evict   = (CMP_W'(count) >= cap_min) || (count == COUNT_W'(WAYS));
    slot_oh = evict ? oldest_oh : free_oh;
  end

  // Next contents of the shard row.
  always_comb begin
    new_valid = valid_row;
    for (int w = 0; w < WAYS; w++) begin
      n_key[w] = e_key[w];
      n_val[w] = e_val[w];
      n_age[w] = e_age[w];
      if (found) begin
        if (match_oh[w]) begin
          n_age[w] = '0;
          if (cmd == slc_pkg::CMD_PUT) begin
            n_val[w] = value_in;
          end
        end else if (valid_row[w] && (e_age[w] < hit_age)) begin
          n_age[w] = e_age[w] + AGE_W'(1);
        end
      end else if (cmd == slc_pkg::CMD_PUT) begin
        if (slot_oh[w]) begin
          new_valid[w] = 1'b1;
          n_key[w]     = key;
          n_val[w]     = value_in;
          n_age[w]     = '0;
        end else if (valid_row[w]) begin
          n_age[w] = e_age[w] + AGE_W'(1);
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      new_row[w*ENTRY_W +: ENTRY_W] = {n_key[w], n_val[w], n_age[w]};
    end
  end

  // Result of the request.
  always_comb begin
    res.hit   = found;
    res.value = (found && (cmd == slc_pkg::CMD_GET)) ? hit_value : '0;
  end

endmodule

`default_nettype wire

### rtl/sharded_lru_cache.sv
// Key-to-value cache split into SHARD_COUNT shards of WAYS entries each, with
// true LRU replacement inside each shard. The shard is the key modulo
// SHARD_COUNT.
// Requests arrive on in_valid/in_ready with cmd, key and value_in; one result
// beat per request leaves on out_valid/out_ready with hit and value_out.
// A get returns the stored value on a hit and zero on a miss; a put updates
// or inserts the key and always returns a zero value.
// The request passes an input register, a shard row read from a single RAM
// of SHARD_COUNT rows (registered read port) and the result register. One
// request is taken per cycle while out_ready keeps the result register
// draining; the single read and single write port of the shard RAM, with a
// bypass for back-to-back requests to the same shard, set that rate.
// When out_ready is low the result register holds and the stages behind it
// fill up; in_ready falls once all three are occupied.
// The capacity register is written through cfg_wen/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset clears every entry's valid bit and sets the capacity to eight; there
// is no clearing pass, so a request may follow reset at once.
`default_nettype none

module sharded_lru_cache #(
  parameter int SHARD_COUNT = 8,
  parameter int WAYS        = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [slc_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        cmd,
  input  wire logic [slc_pkg::KEY_W-1:0]   key,
  input  wire logic [slc_pkg::VAL_W-1:0]   value_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             hit,
  output logic      [slc_pkg::VAL_W-1:0]   value_out
);

  localparam int SHARD_W = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
  localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W = slc_pkg::KEY_W + slc_pkg::VAL_W + AGE_W;
  localparam int ROW_W   = WAYS * ENTRY_W;

  // Capacity register.
  logic [slc_pkg::CAP_W-1:0] cap;

  // Input stage.
  logic                      a_v;
  logic                      a_cmd;
  logic [slc_pkg::KEY_W-1:0] a_key;
  logic [slc_pkg::VAL_W-1:0] a_val;
  logic [slc_pkg::KEY_W-1:0] a_quot;
  logic [slc_pkg::KEY_W-1:0] in_quot;
  logic [SHARD_W-1:0]        a_shard;

  // Row stage.
  logic                      b_v;
  logic                      b_cmd;
  logic [slc_pkg::KEY_W-1:0] b_key;
  logic [slc_pkg::VAL_W-1:0] b_val;
  logic [SHARD_W-1:0]        b_shard;
  logic                      b_fwd;
  logic [ROW_W-1:0]          ram_rdata;
  logic [ROW_W-1:0]          fwd_row;
  logic [ROW_W-1:0]          b_row;
  logic [WAYS-1:0]           b_valid_row;
  logic [ROW_W-1:0]          new_row;
  logic [WAYS-1:0]           new_valid;
  slc_pkg::lookup_res_t      res;

  // Valid bits of every entry, one vector per shard.
  logic [WAYS-1:0]           valid_tab [SHARD_COUNT];

  // Stage movement.
  logic                      b_go;
  logic                      a_go;

  always_comb begin
    b_go     = b_v && (!out_valid || out_ready);
    a_go     = a_v && (!b_v || b_go);
    in_ready = !a_v || a_go;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= slc_pkg::CAP_RESET;
    end else if (cfg_wen) begin
      cap <= cfg_wdata;
    end
  end

  // Shard selection: quotient at the input, remainder from the input register.
  slc_shard_sel #(
    .SHARD_COUNT (SHARD_COUNT)
  ) u_shard_sel (
    .key    (key),
    .quot   (in_quot),
    .key_q  (a_key),
    .quot_q (a_quot),
    .shard  (a_shard)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (in_ready) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_cmd  <= cmd;
      a_key  <= key;
      a_val  <= value_in;
      a_quot <= in_quot;
    end
  end

  // Shard rows: key, value and age of every way.
  slc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SHARD_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .wen   (b_go),
    .waddr (b_shard),
    .wdata (new_row),
    .ren   (a_go),
    .raddr (a_shard),
    .rdata (ram_rdata)
  );

  // Row stage registers; the bypass flag marks a read that raced the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (!b_v || b_go) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_cmd   <= a_cmd;
      b_key   <= a_key;
      b_val   <= a_val;
      b_shard <= a_shard;
      b_fwd   <= b_go && (b_shard == a_shard);
    end
    if (b_go) begin
      fwd_row <= new_row;
    end
  end

  always_comb begin
    b_row       = b_fwd ? fwd_row : ram_rdata;
    b_valid_row = valid_tab[b_shard];
  end

  // Compare, replacement and age update for the selected shard.
  slc_way_logic #(
    .WAYS (WAYS)
  ) u_way_logic (
    .cmd       (b_cmd),
    .key       (b_key),
    .value_in  (b_val),
    .cap       (cap),
    .valid_row (b_valid_row),
    .row       (b_row),
    .new_valid (new_valid),
    .new_row   (new_row),
    .res       (res)
  );

  // Valid bits are cleared at reset and written back with the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SHARD_COUNT; s++) begin
        valid_tab[s] <= '0;
      end
    end else if (b_go) begin
      valid_tab[b_shard] <= new_valid;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      hit       <= res.hit;
      value_out <= res.value;
    end
  end

  // A request never lowers the occupancy of its shard.
  assert property (@(posedge clk) disable iff (rst)
    b_go |-> ($countones(new_valid) >= $countones(b_valid_row)))
    else $error("shard occupancy fell");

  // After a put the shard holds at least one valid entry.
  assert property (@(posedge clk) disable iff (rst)
    (b_go && (b_cmd == slc_pkg::CMD_PUT)) |-> (new_valid != '0))
    else $error("put left its shard empty");

  // A put always returns a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (b_go && (b_cmd == slc_pkg::CMD_PUT)) |=> (value_out == '0))
    else $error("put returned a value");

endmodule

`default_nettype wire

### tb/sharded_lru_cache_test.sv
`default_nettype none

module sharded_lru_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHARD_COUNT  = 8;
  localparam int WAYS         = 8;
  localparam int ENTRIES      = SHARD_COUNT * WAYS;
  localparam int RANDOM_ITEMS = 72;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    logic                      cmd;
    logic [slc_pkg::KEY_W-1:0] key;
    logic [slc_pkg::VAL_W-1:0] value;
  } cache_req_t;

  typedef struct {
    logic                      hit;
    logic [slc_pkg::VAL_W-1:0] value;
  } cache_reply_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wen = 1'b0;
  logic [slc_pkg::CAP_W-1:0] cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      cmd = slc_pkg::CMD_GET;
  logic [slc_pkg::KEY_W-1:0] key = '0;
  logic [slc_pkg::VAL_W-1:0] value_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      hit;
  logic [slc_pkg::VAL_W-1:0] value_out;

  sharded_lru_cache #(
    .SHARD_COUNT(SHARD_COUNT),
    .WAYS       (WAYS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .key      (key),
    .value_in (value_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit      (hit),
    .value_out(value_out)
  );

  // Shadow copy of the cache contents and the capacity register.
  bit                        shadow_valid [ENTRIES];
  logic [slc_pkg::KEY_W-1:0] shadow_key   [ENTRIES];
  logic [slc_pkg::VAL_W-1:0] shadow_value [ENTRIES];
  bit [2:0]                  shadow_age   [ENTRIES];
  logic [slc_pkg::CAP_W-1:0] capacity_setting = slc_pkg::CAP_RESET;

  cache_req_t   request_queue[$];
  cache_reply_t replies_due[$];
  cache_req_t   held_req;
  int           errors = 0;
  int           cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Make one entry the most recent; every younger valid entry ages by one.
  function automatic void promote_entry(int base, int idx);
    bit [2:0] was;
    was = shadow_age[idx];
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w] && shadow_age[base + w] < was) begin
        shadow_age[base + w] = shadow_age[base + w] + 3'd1;
      end
    end
    shadow_age[idx] = '0;
  endfunction

  // Work out the reply to one request and apply its effect to the shadow state.
  function automatic cache_reply_t serve_request(cache_req_t req);
    cache_reply_t reply;
    int base, found, freeway, oldest, count, lim, slot;
    base    = int'(req.key % 32'(SHARD_COUNT)) * WAYS;
    found   = -1;
    freeway = -1;
    oldest  = -1;
    count   = 0;
    lim     = int'(capacity_setting);
    if (lim < 1) lim = 1;
    if (lim > WAYS) lim = WAYS;

    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        count++;
        if (found < 0 && shadow_key[base + w] == req.key) found = w;
        if (oldest < 0 || shadow_age[base + w] > shadow_age[base + oldest]) oldest = w;
      end else if (freeway < 0) begin
        freeway = w;
      end
    end

    reply.hit   = (found >= 0);
    reply.value = '0;
    if (req.cmd == slc_pkg::CMD_GET) begin
      if (found >= 0) begin
        reply.value = shadow_value[base + found];
        promote_entry(base, base + found);
      end
    end else if (found >= 0) begin
      shadow_value[base + found] = req.value;
      promote_entry(base, base + found);
    end else begin
      // A full shard (by the effective capacity) drops its least recent entry.
      if (count >= lim && oldest >= 0) begin
        slot = oldest;
        shadow_valid[base + slot] = 1'b0;
      end else begin
        slot = freeway;
      end
      for (int w = 0; w < WAYS; w++) begin
        if (shadow_valid[base + w]) shadow_age[base + w] = shadow_age[base + w] + 3'd1;
      end
      shadow_valid[base + slot] = 1'b1;
      shadow_key[base + slot]   = req.key;
      shadow_value[base + slot] = req.value;
      shadow_age[base + slot]   = '0;
    end
    return reply;
  endfunction

  function automatic void queue_request(logic c, logic [slc_pkg::KEY_W-1:0] k,
                                        logic [slc_pkg::VAL_W-1:0] v);
    cache_req_t req;
    req.cmd   = c;
    req.key   = k;
    req.value = v;
    request_queue = {request_queue, req};
  endfunction

  // Wait until every request has been taken and every reply has come back.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (request_queue.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Request driver: bursts of beats separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        replies_due = {replies_due, serve_request(held_req)};
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          held_req = request_queue.pop_front();
          in_valid <= 1'b1;
          cmd      <= held_req.cmd;
          key      <= held_req.key;
          value_in <= held_req.value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor, with a receiver stall pattern that changes mode now and then.
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk) begin
    cache_reply_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("result beat with no request outstanding: hit %0b value_out %08h",
                 hit, value_out);
          errors++;
        end else begin
          due = replies_due.pop_front();
          if (hit !== due.hit) begin
            $error("hit mismatch: expected %0b, actual %0b", due.hit, hit);
            errors++;
          end
          if (value_out !== due.value) begin
            $error("value_out mismatch: expected %08h, actual %08h", due.value, value_out);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("sharded_lru_cache regression: fail");
      $finish;
    end
  end

  // Stimulus sequence: directed checks, then random phases at several capacities.
  initial begin
    logic [slc_pkg::CAP_W-1:0] capacities[9];
    logic [slc_pkg::KEY_W-1:0] pool[$];
    logic [slc_pkg::KEY_W-1:0] k;
    int                        pool_n, shard_span;

    capacities = '{4'd15, 4'd2, 4'd0, 4'd5, 4'd9, 4'd1, 4'd8, 4'd3, 4'd6};
    for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes of key and value, a lookup on an empty cache, and an update.
    queue_request(slc_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(slc_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(slc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_request(slc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(slc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(slc_pkg::CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    queue_request(slc_pkg::CMD_GET, 32'h0000_0000, 32'hA5A5_A5A5);
    // Fill one shard, refresh its oldest key, then force an eviction.
    for (int i = 0; i < WAYS; i++) begin
      queue_request(slc_pkg::CMD_PUT, 32'(3 + SHARD_COUNT * i), 32'(32'hC0DE_0000 + i));
    end
    queue_request(slc_pkg::CMD_GET, 32'd3, 32'h0);
    queue_request(slc_pkg::CMD_PUT, 32'(3 + SHARD_COUNT * WAYS), 32'hDEAD_BEEF);
    queue_request(slc_pkg::CMD_GET, 32'(3 + SHARD_COUNT), 32'h0);
    queue_request(slc_pkg::CMD_GET, 32'd3, 32'h0);
    queue_request(slc_pkg::CMD_GET, 32'(3 + SHARD_COUNT * WAYS), 32'h0);
    settle();

    foreach (capacities[p]) begin
      // The capacity register changes only while nothing is in flight.
      @(posedge clk);
      cfg_wen   <= 1'b1;
      cfg_wdata <= capacities[p];
      capacity_setting = capacities[p];
      @(posedge clk);
      cfg_wen <= 1'b0;
      @(negedge clk);

      // A key pool crowded onto shards 0 to shard_span-1 keeps hits and evictions frequent.
      pool.delete();
      pool_n     = $urandom_range(4, 40);
      shard_span = $urandom_range(1, SHARD_COUNT);
      for (int i = 0; i < pool_n; i++) begin
        k = $urandom();
        k = k - (k % 32'(SHARD_COUNT)) + 32'($urandom_range(0, shard_span - 1));
        pool = {pool, k};
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) k = $urandom();
        else k = pool[$urandom_range(0, pool_n - 1)];
        queue_request(($urandom_range(0, 1) == 1) ? slc_pkg::CMD_PUT : slc_pkg::CMD_GET,
                      k, $urandom());
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("sharded_lru_cache regression: pass");
    end else begin
      $display("sharded_lru_cache regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/slc_pkg.sv
rtl/slc_ram.sv
rtl/slc_shard_sel.sv
rtl/slc_way_logic.sv
rtl/sharded_lru_cache.sv
tb/sharded_lru_cache_test.sv
